// File: sv/stepper_limit_homing_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Homing sequencer assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_LIMIT_HOMING_SEQUENCER_ASSERT_SVH
`define STEPPER_LIMIT_HOMING_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLHS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SLHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/slhs_pkg.sv
// ----------------------------------------------------------------------------
// slhs_pkg
// Types, codes and reset values for the stepper homing sequencer.
// ----------------------------------------------------------------------------
package slhs_pkg;

  localparam int unsigned POS_W           = 18;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned SETTLE_W        = 8;
  localparam int unsigned SETTLE_TICKS_DEF = 100;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [SETTLE_W-1:0]     settle_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RELEASE = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_SEEK    = 3'd3,
    PH_SETTLE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OK   = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_HAS_SWITCH     = 3'd0,
    REG_HOME_DIR       = 3'd1,
    REG_POS_DIR        = 3'd2,
    REG_MAX_RELEASE    = 3'd3,
    REG_MAX_HOMING     = 3'd4,
    REG_BACKOFF_STEPS  = 3'd5,
    REG_HOMING_PERIOD  = 3'd6,
    REG_BACKOFF_PERIOD = 3'd7
  } cfg_reg_t;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam cnt_t RST_MAX_RELEASE    = 16'd2000;
  localparam cnt_t RST_MAX_HOMING     = 16'd20000;
  localparam cnt_t RST_BACKOFF_STEPS  = 16'd200;
  localparam cnt_t RST_HOMING_PERIOD  = 16'd10;
  localparam cnt_t RST_BACKOFF_PERIOD = 16'd20;

endpackage

// File: sv/stepper_limit_homing_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_limit_homing_sequencer
// Homing sequencer for one stepper axis with a limit switch: release, backoff,
// seek, settle, zero, release and backoff again. One result word per input word.
// ----------------------------------------------------------------------------
// channel  direction  handshake         payload
// in_      input      in_valid/ready    kind, limit_pressed
// out_     output     out_valid/ready   step_pulse, direction, status, homed, position
// cfg_     input      cfg_we            cfg_idx (register), cfg_wdata (16b)
//
// Each word is decided in the cycle it is accepted and its result is registered;
// one word per cycle while results are taken, result valid the cycle after acceptance.
// The output register frees up in the same cycle it is taken, so in_ready stays
// high while out_ready is high; a stalled result holds in_ready low.
// Reset (rst_n low, synchronous) clears the sequencer to idle and loads the
// register defaults.
// ----------------------------------------------------------------------------
module stepper_limit_homing_sequencer #(
  parameter int unsigned SETTLE_TICKS = slhs_pkg::SETTLE_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic               in_limit_pressed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_step_pulse,
  output logic               out_direction,
  output logic [1:0]         out_status,
  output logic               out_homed,
  output slhs_pkg::pos_t     out_position,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);
  import slhs_pkg::*;

  localparam settle_t SETTLE_LIM  = settle_t'(SETTLE_TICKS);
  localparam logic    SETTLE_ZERO = (SETTLE_TICKS == 0);

  // configuration
  logic    has_switch_r, home_dir_r, pos_dir_r;
  cnt_t    max_release_r, max_homing_r, backoff_steps_r;
  cnt_t    homing_period_r, backoff_period_r;

  // sequencer state
  phase_t  phase_r, phase_nxt;
  logic    second_r, second_nxt;
  cnt_t    step_cnt_r, step_cnt_nxt;
  cnt_t    per_cnt_r, per_cnt_nxt;
  settle_t settle_r, settle_nxt;
  logic    homed_r, homed_nxt;
  pos_t    pos_r, pos_nxt;
  logic    dir_r, dir_nxt;
  status_t fstat_r, fstat_nxt;

  // result register
  logic    out_valid_r;
  logic    pulse_r, pulse;
  logic    odir_r;
  status_t ostat_r, ostat_nxt;
  logic    ohomed_r;
  pos_t    opos_r;

  logic    in_acc;
  logic    clr_cnt;
  cnt_t    per_sel, per_eff, per_inc;
  logic    per_due;
  cnt_t    step_inc;
  settle_t settle_inc;
  pos_t    pos_step;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // period counter shared by release, backoff and seek
  assign per_sel  = (phase_r == PH_SEEK) ? homing_period_r : backoff_period_r;
  assign per_eff  = (per_sel == '0) ? cnt_t'(1) : per_sel;
  assign per_inc  = per_cnt_r + cnt_t'(1);
  assign per_due  = (per_inc >= per_eff);
  assign step_inc = step_cnt_r + cnt_t'(1);
  assign settle_inc = settle_r + settle_t'(1);
  // position moves only while homed
  assign pos_step = !homed_r ? pos_r :
                    (dir_r == pos_dir_r) ? pos_r + pos_t'(1) : pos_r - pos_t'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_switch_r     <= 1'b1;
      home_dir_r       <= 1'b0;
      pos_dir_r        <= 1'b1;
      max_release_r    <= RST_MAX_RELEASE;
      max_homing_r     <= RST_MAX_HOMING;
      backoff_steps_r  <= RST_BACKOFF_STEPS;
      homing_period_r  <= RST_HOMING_PERIOD;
      backoff_period_r <= RST_BACKOFF_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HAS_SWITCH:     has_switch_r     <= cfg_wdata[0];
        REG_HOME_DIR:       home_dir_r       <= cfg_wdata[0];
        REG_POS_DIR:        pos_dir_r        <= cfg_wdata[0];
        REG_MAX_RELEASE:    max_release_r    <= cfg_wdata;
        REG_MAX_HOMING:     max_homing_r     <= cfg_wdata;
        REG_BACKOFF_STEPS:  backoff_steps_r  <= cfg_wdata;
        REG_HOMING_PERIOD:  homing_period_r  <= cfg_wdata;
        REG_BACKOFF_PERIOD: backoff_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    second_nxt   = second_r;
    step_cnt_nxt = step_cnt_r;
    per_cnt_nxt  = per_cnt_r;
    settle_nxt   = settle_r;
    homed_nxt    = homed_r;
    pos_nxt      = pos_r;
    dir_nxt      = dir_r;
    fstat_nxt    = fstat_r;
    pulse        = 1'b0;
    clr_cnt      = 1'b0;
    if (in_acc) begin
      if (in_kind == KIND_START) begin
        second_nxt = 1'b0;
        clr_cnt    = 1'b1;
        if (!has_switch_r) begin
          homed_nxt = 1'b1;
          fstat_nxt = ST_OK;
          phase_nxt = PH_IDLE;
        end else begin
          homed_nxt = 1'b0;
          fstat_nxt = ST_RUN;
          if (in_limit_pressed) begin
            dir_nxt   = !home_dir_r;
            phase_nxt = PH_RELEASE;
          end else begin
            dir_nxt   = home_dir_r;
            phase_nxt = PH_SEEK;
          end
        end
      end else begin
        unique case (phase_r)
          PH_RELEASE: begin
            if (!in_limit_pressed) begin
              clr_cnt = 1'b1;
              if (backoff_steps_r != '0) begin
                phase_nxt = PH_BACKOFF;
              end else if (!second_r) begin
                dir_nxt   = home_dir_r;
                phase_nxt = PH_SEEK;
              end else begin
                pos_nxt   = '0;
                fstat_nxt = ST_OK;
                phase_nxt = PH_IDLE;
              end
            end else if (step_cnt_r >= max_release_r) begin
              clr_cnt   = 1'b1;
              if (second_r) homed_nxt = 1'b0;
              fstat_nxt = ST_FAIL;
              phase_nxt = PH_IDLE;
            end else begin
              per_cnt_nxt = per_due ? '0 : per_inc;
              if (per_due) begin
                pulse        = 1'b1;
                pos_nxt      = pos_step;
                step_cnt_nxt = step_inc;
              end
            end
          end
          PH_BACKOFF: begin
            per_cnt_nxt = per_due ? '0 : per_inc;
            if (per_due) begin
              pulse        = 1'b1;
              pos_nxt      = pos_step;
              step_cnt_nxt = step_inc;
              if (step_inc >= backoff_steps_r) begin
                clr_cnt = 1'b1;
                if (!second_r) begin
                  dir_nxt   = home_dir_r;
                  phase_nxt = PH_SEEK;
                end else begin
                  pos_nxt   = '0;
                  fstat_nxt = ST_OK;
                  phase_nxt = PH_IDLE;
                end
              end
            end
          end
          PH_SEEK: begin
            if (in_limit_pressed) begin
              clr_cnt = 1'b1;
              if (SETTLE_ZERO) begin
                pos_nxt    = '0;
                homed_nxt  = 1'b1;
                second_nxt = 1'b1;
                dir_nxt    = !home_dir_r;
                phase_nxt  = PH_RELEASE;
              end else begin
                phase_nxt = PH_SETTLE;
              end
            end else if (step_cnt_r >= max_homing_r) begin
              clr_cnt   = 1'b1;
              if (second_r) homed_nxt = 1'b0;
              fstat_nxt = ST_FAIL;
              phase_nxt = PH_IDLE;
            end else begin
              per_cnt_nxt = per_due ? '0 : per_inc;
              if (per_due) begin
                pulse        = 1'b1;
                step_cnt_nxt = step_inc;
              end
            end
          end
          PH_SETTLE: begin
            settle_nxt = settle_inc;
            if (settle_inc >= SETTLE_LIM) begin
              clr_cnt    = 1'b1;
              pos_nxt    = '0;
              homed_nxt  = 1'b1;
              second_nxt = 1'b1;
              dir_nxt    = !home_dir_r;
              phase_nxt  = PH_RELEASE;
            end
          end
          default: ;
        endcase
      end
      if (clr_cnt) begin
        step_cnt_nxt = '0;
        per_cnt_nxt  = '0;
        settle_nxt   = '0;
      end
    end
  end

  // result word
  always_comb begin
    ostat_nxt = (phase_nxt != PH_IDLE) ? ST_RUN : fstat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      second_r    <= 1'b0;
      step_cnt_r  <= '0;
      per_cnt_r   <= '0;
      settle_r    <= '0;
      homed_r     <= 1'b0;
      pos_r       <= '0;
      dir_r       <= 1'b0;
      fstat_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      second_r   <= second_nxt;
      step_cnt_r <= step_cnt_nxt;
      per_cnt_r  <= per_cnt_nxt;
      settle_r   <= settle_nxt;
      homed_r    <= homed_nxt;
      pos_r      <= pos_nxt;
      dir_r      <= dir_nxt;
      fstat_r    <= fstat_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pulse_r  <= pulse;
      odir_r   <= dir_nxt;
      ostat_r  <= ostat_nxt;
      ohomed_r <= homed_nxt;
      opos_r   <= pos_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_pulse = pulse_r;
  assign out_direction  = odir_r;
  assign out_status     = ostat_r;
  assign out_homed      = ohomed_r;
  assign out_position   = opos_r;

`include "stepper_limit_homing_sequencer_assert.svh"

  `SLHS_ASSERT_NEXT(a_acc_fills_out, in_acc, out_valid_r, "accepted word left no result")
  `SLHS_ASSERT_NEXT(a_idle_holds, !in_acc,
    $stable(phase_r) && $stable(pos_r) && $stable(homed_r), "state moved without a word")
  `SLHS_ASSERT_NEXT(a_pos_needs_homed, !homed_r, homed_r || $stable(pos_r),
    "position moved while not homed")
  `SLHS_ASSERT_SAME(a_pulse_status, out_valid_r && pulse_r,
    ostat_r == ST_RUN || ostat_r == ST_OK, "step pulse on idle or failed status")

endmodule
